// ----- rtl/spc_pkg.sv -----
package spc_pkg;

	localparam int NUM_ENTRIES_DEF = 256;

	localparam int CFG_W = 9;
	localparam int QW_A = 8;
	localparam int QW_B = 25;
	localparam int DW_B = 10;

	typedef enum logic [1:0] {
		REG_STATE_COUNT   = 2'd0,
		REG_DECAY_ENABLED = 2'd1,
		REG_DECAY_START   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		CAT_ZERO = 3'd0,
		CAT_FIX0 = 3'd1,
		CAT_FIX1 = 3'd2,
		CAT_HUE  = 3'd3,
		CAT_TAIL = 3'd4
	} cat_t;

	typedef struct packed {
		cat_t       cat;
		logic [7:0] span;
		logic [8:0] i1;
		logic [8:0] tt;
	} side_a_t;

	localparam logic [24:0] DEG60  = 25'(60 * 65536);
	localparam logic [24:0] DEG120 = 25'(120 * 65536);
	localparam logic [24:0] DEG180 = 25'(180 * 65536);
	localparam logic [24:0] DEG240 = 25'(240 * 65536);
	localparam logic [24:0] DEG300 = 25'(300 * 65536);
	localparam logic [24:0] DEG360 = 25'(360 * 65536);
	localparam logic [24:0] DEG200 = 25'(200 * 65536);

	localparam logic [7:0] HI_CH = 8'd217;
	localparam logic [7:0] LO_CH = 8'd54;
	localparam logic [15:0] FADE_K = 16'd53740;

	localparam logic [33:0] MID_BASE = 34'd3440640000;
	localparam logic [11:0] MID_MUL = 12'd2601;
	localparam logic [12:0] DIV15_MUL = 13'd4370;

	localparam logic [31:0] RGBA_FIX0 = {8'd14, 8'd16, 8'd20, 8'd0};
	localparam logic [31:0] RGBA_FIX1 = {8'd236, 8'd240, 8'd238, 8'd255};

endpackage

// ----- rtl/spc_divpipe.sv -----
module spc_divpipe #(
	parameter int QW = 8,
	parameter int DW = 8,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] in_rem,
	input  logic [QW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] out_quo,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	logic          vld_s  [0:QW];
	logic [DW-1:0] rem_s  [0:QW];
	logic [QW-1:0] num_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rem;
	assign num_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[j], num_s[j][QW-1]};
		assign ge    = trial >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? DW'(trial - {1'b0, den_s[j]}) : trial[DW-1:0];
				num_s[j+1]  <= {num_s[j][QW-2:0], ge};
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign out_quo  = num_s[QW];
	assign out_rem  = rem_s[QW];
	assign out_side = side_s[QW];

endmodule

// ----- rtl/state_palette_colour_unit.sv -----
// Path from index to colour: s1, modulo divider, s2, fraction divider, s4-s9, outputs.
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// Most latency is in two bit-per-stage dividers: the hue index modulo (8 stages)
// and the hue fraction or fade step (25 stages).
// Reset clears the pipeline valid bits and sets state_count to 2, the other registers to 0.
module state_palette_colour_unit #(
	parameter int NUM_ENTRIES = spc_pkg::NUM_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [1:0]               wr_index,
	input  logic [spc_pkg::CFG_W-1:0] wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               state_index,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue,
	output logic [7:0]               alpha
);
	import spc_pkg::*;

	logic [8:0] state_count_q;
	logic       decay_enabled_q;
	logic [7:0] decay_start_q;

	logic en;

	logic [8:0] states;
	logic [8:0] live;
	logic [8:0] idx9;
	logic [8:0] ds9;
	side_a_t    side_in;

	logic       vld_s1;
	side_a_t    side_s1;
	logic [7:0] ka_s1;

	logic            a_vld;
	logic [7:0]      a_quo;
	logic [7:0]      a_rem;
	logic [$bits(side_a_t)-1:0] a_side_v;
	side_a_t         a_side;

	logic [33:0] numb;
	logic [9:0]  denb;

	logic        vld_s2;
	cat_t        cat_s2;
	logic [33:0] numb_s2;
	logic [9:0]  denb_s2;

	logic        b_vld;
	logic [24:0] b_quo;
	logic [9:0]  b_rem;
	logic [2:0]  b_side;
	cat_t        b_cat;

	logic [24:0] h_raw;

	logic        vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	cat_t        cat_s4, cat_s5, cat_s6, cat_s7, cat_s8, cat_s9;
	logic [31:0] rgba_s4, rgba_s5, rgba_s6, rgba_s7, rgba_s8, rgba_s9;
	logic [2:0]  sec_s5, sec_s6, sec_s7, sec_s8, sec_s9;
	logic [24:0] h_s4;
	logic [16:0] t_s4;
	logic [32:0] prodf_s4;
	logic [24:0] p_s5;
	logic [16:0] f_s5;
	logic [7:0]  alpha_s5;
	logic [21:0] d_s6;
	logic [33:0] mprod_s7;
	logic [11:0] v_s8;
	logic [7:0]  x_s9;

	logic [2:0]  sec_n;
	logic [24:0] p_n;
	logic [33:0] msum;
	logic [24:0] xprod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q   <= 9'd2;
			decay_enabled_q <= 1'b0;
			decay_start_q   <= 8'd0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_STATE_COUNT:   state_count_q   <= wr_data;
				REG_DECAY_ENABLED: decay_enabled_q <= wr_data[0];
				REG_DECAY_START:   decay_start_q   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	always_comb begin
		idx9   = {1'b0, state_index};
		ds9    = {1'b0, decay_start_q};
		states = (state_count_q > 9'(NUM_ENTRIES)) ? 9'(NUM_ENTRIES) : state_count_q;
		live   = decay_enabled_q ? ds9 : states;
		side_in.span = (live > 9'd2) ? 8'(live - 9'd2) : 8'(NUM_ENTRIES - 2);
		side_in.tt   = 9'(states - ds9 + 9'd1);
		side_in.i1   = 9'(idx9 - ds9 + 9'd1);
		if (idx9 >= 9'(NUM_ENTRIES)) begin
			side_in.cat = CAT_ZERO;
		end else if (decay_enabled_q && ds9 < states && idx9 >= ds9 && idx9 < states) begin
			side_in.cat = CAT_TAIL;
		end else if (state_index == 8'd0) begin
			side_in.cat = CAT_FIX0;
		end else if (state_index == 8'd1) begin
			side_in.cat = CAT_FIX1;
		end else begin
			side_in.cat = CAT_HUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			ka_s1   <= 8'(state_index - 8'd2);
		end
	end

	spc_divpipe #(
		.QW(QW_A),
		.DW(8),
		.SW($bits(side_a_t))
	) u_div_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.in_rem  (8'd0),
		.in_num  (ka_s1),
		.in_den  (side_s1.span),
		.in_side (side_s1),
		.out_vld (a_vld),
		.out_quo (a_quo),
		.out_rem (a_rem),
		.out_side(a_side_v)
	);

	assign a_side = side_a_t'(a_side_v);

	always_comb begin
		if (a_side.cat == CAT_TAIL) begin
			numb = (34'(a_side.i1) << 17) | 34'(a_side.tt);
			denb = {a_side.tt, 1'b0};
		end else begin
			numb = (34'(18'(a_rem) * 18'd600) << 16) | 34'(a_side.span);
			denb = {1'b0, a_side.span, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= a_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cat_s2  <= a_side.cat;
			numb_s2 <= numb;
			denb_s2 <= denb;
		end
	end

	spc_divpipe #(
		.QW(QW_B),
		.DW(DW_B),
		.SW(3)
	) u_div_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.in_rem  ({1'b0, numb_s2[33:25]}),
		.in_num  (numb_s2[24:0]),
		.in_den  (denb_s2),
		.in_side (cat_s2),
		.out_vld (b_vld),
		.out_quo (b_quo),
		.out_rem (b_rem),
		.out_side(b_side)
	);

	assign b_cat = cat_t'(b_side);
	assign h_raw = 25'(DEG200 + b_quo);

	always_comb begin
		if (p_s5 < 25'(DEG60)) begin
			msum = 34'(p_s5);
		end else begin
			msum = 34'(25'({DEG60, 1'b0}) - p_s5);
		end
	end

	always_comb begin
		if (h_s4 < DEG60) begin
			sec_n = 3'd0;
			p_n   = h_s4;
		end else if (h_s4 < DEG120) begin
			sec_n = 3'd1;
			p_n   = h_s4;
		end else if (h_s4 < DEG180) begin
			sec_n = 3'd2;
			p_n   = h_s4 - DEG120;
		end else if (h_s4 < DEG240) begin
			sec_n = 3'd3;
			p_n   = h_s4 - DEG120;
		end else if (h_s4 < DEG300) begin
			sec_n = 3'd4;
			p_n   = h_s4 - DEG240;
		end else begin
			sec_n = 3'd5;
			p_n   = h_s4 - DEG240;
		end
	end

	assign xprod = 25'(v_s8) * 25'(DIV15_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s4    <= b_vld;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			out_valid <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cat_s4   <= b_cat;
			h_s4     <= (h_raw >= DEG360) ? h_raw - DEG360 : h_raw;
			t_s4     <= b_quo[16:0];
			prodf_s4 <= 33'(b_quo[16:0]) * 33'(FADE_K);
			case (b_cat)
				CAT_FIX0: rgba_s4 <= RGBA_FIX0;
				CAT_FIX1: rgba_s4 <= RGBA_FIX1;
				default:  rgba_s4 <= 32'd0;
			endcase

			cat_s5   <= cat_s4;
			rgba_s5  <= rgba_s4;
			sec_s5   <= sec_n;
			p_s5     <= p_n;
			f_s5     <= 17'(33'd65536 - ((prodf_s4 + 33'd32768) >> 16));
			alpha_s5 <= 8'((25'd255 * 25'(17'd65536 - t_s4) + 25'd32768) >> 16);

			cat_s6 <= cat_s5;
			sec_s6 <= sec_s5;
			d_s6   <= msum[21:0];
			if (cat_s5 == CAT_TAIL) begin
				rgba_s6 <= {8'((25'd236 * 25'(f_s5) + 25'd32768) >> 16),
					8'((25'd240 * 25'(f_s5) + 25'd32768) >> 16),
					8'((25'd238 * 25'(f_s5) + 25'd32768) >> 16),
					alpha_s5};
			end else begin
				rgba_s6 <= rgba_s5;
			end

			cat_s7   <= cat_s6;
			sec_s7   <= sec_s6;
			rgba_s7  <= rgba_s6;
			mprod_s7 <= 34'(d_s6) * 34'(MID_MUL);

			cat_s8  <= cat_s7;
			sec_s8  <= sec_s7;
			rgba_s8 <= rgba_s7;
			v_s8    <= 12'(34'(mprod_s7 + MID_BASE) >> 22);

			cat_s9  <= cat_s8;
			sec_s9  <= sec_s8;
			rgba_s9 <= rgba_s8;
			x_s9    <= 8'(xprod >> 16);

			if (cat_s9 == CAT_HUE) begin
				alpha <= 8'd255;
				case (sec_s9)
					3'd0: begin
						red <= HI_CH; green <= x_s9; blue <= LO_CH;
					end
					3'd1: begin
						red <= x_s9; green <= HI_CH; blue <= LO_CH;
					end
					3'd2: begin
						red <= LO_CH; green <= HI_CH; blue <= x_s9;
					end
					3'd3: begin
						red <= LO_CH; green <= x_s9; blue <= HI_CH;
					end
					3'd4: begin
						red <= x_s9; green <= LO_CH; blue <= HI_CH;
					end
					default: begin
						red <= HI_CH; green <= LO_CH; blue <= x_s9;
					end
				endcase
			end else begin
				red   <= rgba_s9[31:24];
				green <= rgba_s9[23:16];
				blue  <= rgba_s9[15:8];
				alpha <= rgba_s9[7:0];
			end
		end
	end

	logic unused_ok;
	assign unused_ok = ^{a_quo, b_rem};

endmodule

// ----- sim/state_palette_colour_unit_tb.sv -----
module state_palette_colour_unit_tb;
	import spc_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_WAIT = 50;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [CFG_W-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] state_index;
	logic out_valid;
	logic out_stall;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	logic [8:0] cfg_states;
	logic cfg_decay_on;
	logic [7:0] cfg_decay_first;

	rgba_t colour_queue[$];
	int idle_pct;
	int stall_pct;
	int errors;
	int n_sent;
	int n_checked;
	int quiet_cycles;

	state_palette_colour_unit uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .state_index(state_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .alpha(alpha)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] hsv_mid(input longint unsigned h);
		longint unsigned dd, p, q, d, num, den;
		dd = 60 * 65536;
		p = h % (120 * 65536);
		q = (p >= dd) ? p - dd : dd - p;
		d = dd - q;
		num = 255 * (17 * dd + 51 * d);
		den = 80 * dd;
		return 8'((num * 2 + den) / (den * 2));
	endfunction

	function automatic longint unsigned fade_ch(input longint unsigned ch, input longint unsigned f);
		return ((ch * f + 32768) >> 16) & 255;
	endfunction

	function automatic rgba_t palette_colour(input logic [7:0] s);
		rgba_t c;
		longint unsigned states, live, span, k, h, x, tt, i1, t, f;
		states = (cfg_states > 256) ? 256 : cfg_states;
		if (cfg_decay_on && cfg_decay_first < states && s >= cfg_decay_first && s < states) begin
			tt = states - cfg_decay_first + 1;
			i1 = s - cfg_decay_first + 1;
			t = (i1 * 65536 * 2 + tt) / (tt * 2);
			f = 65536 - ((53740 * t + 32768) >> 16);
			c.r = 8'(fade_ch(236, f));
			c.g = 8'(fade_ch(240, f));
			c.b = 8'(fade_ch(238, f));
			c.a = 8'(((255 * (65536 - t) + 32768) >> 16) & 255);
			return c;
		end
		if (s == 0) return RGBA_FIX0;
		if (s == 1) return RGBA_FIX1;
		live = cfg_decay_on ? cfg_decay_first : states;
		span = (live > 2) ? live - 2 : 254;
		k = (s - 2) % span;
		h = 200 * 65536 + (300 * k * 65536 * 2 + span) / (span * 2);
		if (h >= 360 * 65536) h -= 360 * 65536;
		x = hsv_mid(h);
		c.a = 8'd255;
		if (h < 60 * 65536) {c.r, c.g, c.b} = {HI_CH, 8'(x), LO_CH};
		else if (h < 120 * 65536) {c.r, c.g, c.b} = {8'(x), HI_CH, LO_CH};
		else if (h < 180 * 65536) {c.r, c.g, c.b} = {LO_CH, HI_CH, 8'(x)};
		else if (h < 240 * 65536) {c.r, c.g, c.b} = {LO_CH, 8'(x), HI_CH};
		else if (h < 300 * 65536) {c.r, c.g, c.b} = {8'(x), LO_CH, HI_CH};
		else {c.r, c.g, c.b} = {HI_CH, LO_CH, 8'(x)};
		return c;
	endfunction

	always @(negedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		rgba_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (colour_queue.size() == 0) begin
				errors++;
				$display("%0t: colour %h%h%h%h with none expected", $time, red, green, blue, alpha);
			end else begin
				want = colour_queue.pop_front();
				if (want.r !== red) begin
					errors++;
					$display("%0t: red expected %0d got %0d", $time, want.r, red);
				end
				if (want.g !== green) begin
					errors++;
					$display("%0t: green expected %0d got %0d", $time, want.g, green);
				end
				if (want.b !== blue) begin
					errors++;
					$display("%0t: blue expected %0d got %0d", $time, want.b, blue);
				end
				if (want.a !== alpha) begin
					errors++;
					$display("%0t: alpha expected %0d got %0d", $time, want.a, alpha);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress, %0d colours outstanding", $time, colour_queue.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_index(input logic [7:0] s);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		state_index <= s;
		do @(posedge clk); while (in_stall);
		colour_queue.push_back(palette_colour(s));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(negedge clk);
		while (colour_queue.size() != 0) @(negedge clk);
		repeat (PIPE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_STATE_COUNT: cfg_states = val;
			REG_DECAY_ENABLED: cfg_decay_on = val[0];
			REG_DECAY_START: cfg_decay_first = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_palette(input int sc, input int de, input int ds);
		drain_pipe();
		write_reg(REG_STATE_COUNT, CFG_W'(sc));
		write_reg(REG_DECAY_ENABLED, CFG_W'(de));
		write_reg(REG_DECAY_START, CFG_W'(ds));
	endtask

	task automatic test_reset_palette();
		send_index(8'd0);
		send_index(8'd1);
		send_index(8'd2);
		send_index(8'd128);
		send_index(8'd255);
	endtask

	task automatic test_hue_cycle();
		set_palette(256, 0, 0);
		send_index(8'd2);
		send_index(8'd3);
		send_index(8'd85);
		send_index(8'd170);
		send_index(8'd255);
		set_palette(511, 0, 0);
		send_index(8'd200);
		send_index(8'd255);
		set_palette(0, 0, 255);
		send_index(8'd7);
		set_palette(3, 0, 0);
		send_index(8'd2);
		send_index(8'd9);
	endtask

	task automatic test_decay_tail();
		set_palette(256, 1, 0);
		send_index(8'd0);
		send_index(8'd1);
		send_index(8'd255);
		set_palette(100, 1, 40);
		send_index(8'd39);
		send_index(8'd40);
		send_index(8'd99);
		send_index(8'd100);
		set_palette(50, 1, 200);
		send_index(8'd60);
		send_index(8'd210);
		drain_pipe();
		write_reg(REG_UNUSED, 9'h1FF);
		send_index(8'd30);
	endtask

	task automatic test_random_phase(input int n, input int idle, input int stall);
		int sc, ds;
		idle_pct = idle;
		stall_pct = stall;
		for (int blk = 0; blk < 4; blk++) begin
			case ($urandom_range(3))
				0: sc = 256;
				1: sc = $urandom_range(0, 3);
				default: sc = $urandom_range(0, 511);
			endcase
			ds = ($urandom_range(3) == 0) ? (($urandom_range(1)) ? 0 : 255) : $urandom_range(255);
			set_palette(sc, $urandom_range(1), ds);
			for (int i = 0; i < n / 4; i++) begin
				if (blk == 2 && i == n / 8) drain_pipe();
				if ($urandom_range(3) == 0) send_index(8'(ds + $urandom_range(0, 3) - 1));
				else send_index(8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_STATE_COUNT;
		wr_data = '0;
		in_valid = 1'b0;
		state_index = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		quiet_cycles = 0;
		cfg_states = 9'd2;
		cfg_decay_on = 1'b0;
		cfg_decay_first = 8'd0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_palette();
		test_hue_cycle();
		test_decay_tail();
		test_random_phase(400, 0, 0);
		test_random_phase(400, 67, 0);
		test_random_phase(400, 0, 67);
		test_random_phase(400, 28, 28);
		drain_pipe();
		$display("Sent %0d state indices over hue, fixed and decay palettes, checked %0d colours,",
			n_sent, n_checked);
		$display("with sender gaps and output stalls in four mixes; %0d mismatches.", errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
